[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files. Each macro checks a property on the
// rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define PTD_ASSERT_NOW(lbl, ante, cons)
`define PTD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/ptd_pkg.sv]
`default_nettype none
package ptd_pkg;

   // Default width of the candidate word.
   localparam int NUM_WIDTH_DEF = 32;

   // The first odd trial divisor, and the step between trial divisors.
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP  = 2;

   typedef enum logic [1:0] {
      PTD_IDLE,
      PTD_START,
      PTD_WAIT,
      PTD_DONE
   } ptd_state_type;

   // Control from the sequencer to the shared divider.
   typedef struct packed {
      logic start;
   } ptd_div_ctrl_type;

   // Status from the shared divider back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } ptd_div_stat_type;

endpackage
`default_nettype wire

[rtl/primality_trial_division.sv]
// Negative, zero, one, two and even words get a result in the cycle after acceptance, with no division;
// odd words of three or more run one division in the shared divider for each trial divisor.
// Throughput: one word at a time; the worst case is a large prime, about 23170 trial divisors
// at NUM_WIDTH = 32, each tried in turn on the one-bit-per-cycle shared divider.
// Reset is synchronous and active high; it returns the sequencer and the divider to idle.
`default_nettype none
`include "assert_macros.svh"
module primality_trial_division #(
   parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic signed [NUM_WIDTH-1:0] req_candidate,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic                        rsp_prime
);

   localparam logic [NUM_WIDTH-1:0] FIRST_DIV = NUM_WIDTH'(ptd_pkg::FIRST_DIVISOR);
   localparam logic [NUM_WIDTH-1:0] DIV_STEP  = NUM_WIDTH'(ptd_pkg::DIVISOR_STEP);

   ptd_pkg::ptd_state_type    state_ff, state_in;
   logic [NUM_WIDTH-1:0]      cand_ff, cand_in;
   logic [NUM_WIDTH-1:0]      d_ff, d_in;
   logic                      prime_ff, prime_in;

   ptd_pkg::ptd_div_ctrl_type div_ctrl;
   ptd_pkg::ptd_div_stat_type div_stat;
   logic [NUM_WIDTH-1:0]      quotient;
   logic [NUM_WIDTH-1:0]      remainder;

   logic [NUM_WIDTH-1:0]      cand_u;
   logic                      accept;
   logic                      quick;
   logic                      quick_prime;
   logic                      past_bound;
   logic                      divides;

   assign cand_u = $unsigned(req_candidate);
   assign accept = req_valid && !req_stall;

   // Words that are settled without any division. A negative word has its sign bit set;
   // zero and one have every bit above the lowest clear; two is the only even prime.
   always_comb begin
      quick       = 1'b1;
      quick_prime = 1'b0;
      if (cand_u[NUM_WIDTH-1] || (cand_u[NUM_WIDTH-1:1] == '0)) begin
         quick_prime = 1'b0;
      end else if (cand_u == NUM_WIDTH'(2)) begin
         quick_prime = 1'b1;
      end else if (!cand_u[0]) begin
         quick_prime = 1'b0;
      end else begin
         quick = 1'b0;
      end
   end

   // One division gives both the bound test and the remainder test. The loop ends with
   // "prime" once the divisor exceeds the quotient, which is the same as d*d > candidate,
   // and ends with "not prime" as soon as a divisor leaves no remainder.
   assign past_bound = d_ff > quotient;
   assign divides    = remainder == '0;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::PTD_IDLE: begin
            if (accept) begin
               state_in = quick ? ptd_pkg::PTD_DONE : ptd_pkg::PTD_START;
            end
         end
         ptd_pkg::PTD_START: begin
            state_in = ptd_pkg::PTD_WAIT;
         end
         ptd_pkg::PTD_WAIT: begin
            if (div_stat.done) begin
               state_in = (past_bound || divides) ? ptd_pkg::PTD_DONE : ptd_pkg::PTD_START;
            end
         end
         ptd_pkg::PTD_DONE: begin
            if (!rsp_stall) begin
               state_in = ptd_pkg::PTD_IDLE;
            end
         end
         default: begin
            state_in = ptd_pkg::PTD_IDLE;
         end
      endcase
   end

   // Handshake and divider control, decoded from the state register alone.
   always_comb begin
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      div_ctrl.start = 1'b0;
      unique case (state_ff)
         ptd_pkg::PTD_IDLE:  req_stall      = 1'b0;
         ptd_pkg::PTD_START: div_ctrl.start = 1'b1;
         ptd_pkg::PTD_WAIT:  req_stall      = 1'b1;
         ptd_pkg::PTD_DONE:  rsp_valid      = 1'b1;
         default:            req_stall      = 1'b1;
      endcase
   end

   // The candidate, the current trial divisor and the verdict.
   always_comb begin
      cand_in  = cand_ff;
      d_in     = d_ff;
      prime_in = prime_ff;
      if (accept) begin
         cand_in  = cand_u;
         d_in     = FIRST_DIV;
         prime_in = quick_prime;
      end else if ((state_ff == ptd_pkg::PTD_WAIT) && div_stat.done) begin
         if (past_bound) begin
            prime_in = 1'b1;
         end else if (divides) begin
            prime_in = 1'b0;
         end else begin
            d_in = d_ff + DIV_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::PTD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      d_ff     <= d_in;
      prime_ff <= prime_in;
   end

   ptd_divider #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (cand_ff),
      .divisor   (d_ff),
      .stat      (div_stat),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign rsp_prime = prime_ff;

   // A new division is never started while the divider is still working.
   `PTD_ASSERT_NOW(a_start_when_free, div_ctrl.start, !div_stat.busy)
   // Every trial divisor is odd.
   `PTD_ASSERT_NOW(a_divisor_odd, state_ff == ptd_pkg::PTD_WAIT, d_ff[0])
   // A prime verdict only ever goes out for a positive word that is odd or equal to two.
   `PTD_ASSERT_NOW(a_prime_shape, rsp_valid && rsp_prime,
      !cand_ff[NUM_WIDTH-1] && (cand_ff[0] || (cand_ff == NUM_WIDTH'(2))))
   // Once a word is taken, no further word is taken until its result has gone.
   `PTD_ASSERT_NEXT(a_busy_after_accept, accept, req_stall)

endmodule
`default_nettype wire

[rtl/ptd_divider.sv]
`default_nettype none
// Restoring divider that produces one quotient bit per cycle.
module ptd_divider #(
   parameter int NUM_WIDTH = ptd_pkg::NUM_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ptd_pkg::ptd_div_ctrl_type    ctrl,
   input  wire logic [NUM_WIDTH-1:0]         dividend,
   input  wire logic [NUM_WIDTH-1:0]         divisor,
   output      ptd_pkg::ptd_div_stat_type    stat,
   output      logic [NUM_WIDTH-1:0]         quotient,
   output      logic [NUM_WIDTH-1:0]         remainder
);

   localparam int CW = $clog2(NUM_WIDTH + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;

   logic [NUM_WIDTH:0]   shifted;
   logic [NUM_WIDTH:0]   diff;
   logic                 take;

   assign shifted = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign take    = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (ctrl.start) begin
         busy_in  = 1'b1;
         count_in = CW'(NUM_WIDTH);
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits the word.
         rem_in   = take ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
         quo_in   = {quo_ff[NUM_WIDTH-2:0], take};
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire
